### src/i2cmbe_pkg.sv
package i2cmbe_pkg;

	localparam int BYTE_BITS = 8;
	localparam int BIT_IDX_W = $clog2(BYTE_BITS) + 1;
	localparam int HP_W = 16;
	localparam int TO_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic CFG_IDX_HALF_PERIOD = 1'b0;
	localparam logic CFG_IDX_ACK_TIMEOUT = 1'b1;

	localparam logic [HP_W-1:0] HP_RESET = HP_W'(5);
	localparam logic [TO_W-1:0] TO_RESET = TO_W'(250);

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_STOP = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_READ = 2'd3;

	typedef struct packed {
		logic cmd_valid;
		logic [1:0] kind;
		logic [BYTE_BITS-1:0] tx_byte;
		logic ack_to_send;
		logic sda_sample;
	} item_t;

	typedef struct packed {
		logic scl_level;
		logic sda_level;
		logic sda_drive;
		logic busy_res;
		logic done_res;
		logic [BYTE_BITS-1:0] rx_byte;
		logic acked;
		logic timed_out;
	} res_t;

endpackage

### src/i2cmbe_in_stage.sv
module i2cmbe_in_stage
	import i2cmbe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t in_item,
	input  logic  step_en,
	output logic  valid_s1,
	output item_t item_s1
);

	logic take;

	assign in_stall = valid_s1 && !step_en;
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_item;
		end
	end

endmodule

### src/i2cmbe_engine.sv
module i2cmbe_engine
	import i2cmbe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  step_en,
	input  item_t                 item_s1,
	output res_t                  res
);

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_SP_A, PH_SP_B, PH_SP_C,
		PH_WR_PRE, PH_WR_LOW, PH_WR_HIGH, PH_WA_REL, PH_WA_HIGH, PH_WA_POLL,
		PH_WA_END, PH_RD_PRE, PH_RD_HIGH, PH_RD_LOW, PH_AK_PRE, PH_AK_SET,
		PH_AK_HIGH, PH_AK_LOW
	} phase_t;

	logic [HP_W-1:0] half_period_q;
	logic [TO_W-1:0] ack_timeout_q;

	phase_t phase_q, phase_n, enter_ph;
	logic [BIT_IDX_W-1:0] bit_q, bit_n;
	logic [HP_W-1:0] tick_q, tick_n, tick_inc, hp;
	logic [TO_W-1:0] wait_q, wait_n;
	logic [TO_W:0] wait_inc;
	logic [BYTE_BITS-1:0] shift_q, shift_n, rx_q, rx_n;
	logic ackb_q, ackb_n;
	logic scl_q, scl_n, sda_q, sda_n, drv_q, drv_n;
	logic acked_q, acked_n, to_q, to_n;
	logic do_enter, done_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HP_RESET;
			ack_timeout_q <= TO_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_HALF_PERIOD: half_period_q <= cfg_data[HP_W-1:0];
				CFG_IDX_ACK_TIMEOUT: ack_timeout_q <= cfg_data[TO_W-1:0];
				default: ;
			endcase
		end
	end

	assign hp = (half_period_q == '0) ? HP_W'(1) : half_period_q;
	assign tick_inc = tick_q + HP_W'(1);
	assign wait_inc = {1'b0, wait_q} + (TO_W+1)'(1);

	always_comb begin
		phase_n = phase_q;
		enter_ph = PH_IDLE;
		do_enter = 1'b0;
		bit_n = bit_q;
		tick_n = tick_q;
		wait_n = wait_q;
		shift_n = shift_q;
		rx_n = rx_q;
		ackb_n = ackb_q;
		scl_n = scl_q;
		sda_n = sda_q;
		drv_n = drv_q;
		acked_n = acked_q;
		to_n = to_q;
		done_n = 1'b0;

		case (phase_q)
			PH_IDLE: begin
				if (item_s1.cmd_valid) begin
					bit_n = '0;
					ackb_n = item_s1.ack_to_send;
					do_enter = 1'b1;
					case (item_s1.kind)
						KIND_START: enter_ph = PH_ST_A;
						KIND_STOP: enter_ph = PH_SP_A;
						KIND_WRITE: begin
							shift_n = item_s1.tx_byte;
							acked_n = 1'b0;
							to_n = 1'b0;
							enter_ph = PH_WR_PRE;
						end
						default: begin
							shift_n = '0;
							enter_ph = PH_RD_PRE;
						end
					endcase
				end
			end
			PH_WA_POLL: begin
				if (!item_s1.sda_sample) begin
					acked_n = 1'b1;
					do_enter = 1'b1;
					enter_ph = PH_WA_END;
				end else if (wait_inc > {1'b0, ack_timeout_q}) begin
					acked_n = 1'b0;
					to_n = 1'b1;
					do_enter = 1'b1;
					enter_ph = PH_SP_A;
				end else begin
					wait_n = wait_inc[TO_W-1:0];
				end
			end
			default: begin
				tick_n = tick_inc;
				if (tick_inc >= hp) begin
					do_enter = 1'b1;
					case (phase_q)
						PH_ST_A: enter_ph = PH_ST_B;
						PH_ST_B: enter_ph = PH_ST_C;
						PH_SP_A: enter_ph = PH_SP_B;
						PH_SP_B: enter_ph = PH_SP_C;
						PH_WR_PRE: enter_ph = PH_WR_LOW;
						PH_WR_LOW: enter_ph = PH_WR_HIGH;
						PH_WR_HIGH: begin
							shift_n = {shift_q[BYTE_BITS-2:0], 1'b0};
							bit_n = bit_q + BIT_IDX_W'(1);
							enter_ph = (bit_n >= BIT_IDX_W'(BYTE_BITS)) ? PH_WA_REL
								: PH_WR_LOW;
						end
						PH_WA_REL: enter_ph = PH_WA_HIGH;
						PH_WA_HIGH: enter_ph = PH_WA_POLL;
						PH_RD_PRE: enter_ph = PH_RD_HIGH;
						PH_RD_HIGH: begin
							shift_n = {shift_q[BYTE_BITS-2:0], item_s1.sda_sample};
							bit_n = bit_q + BIT_IDX_W'(1);
							enter_ph = PH_RD_LOW;
						end
						PH_RD_LOW: begin
							if (bit_q >= BIT_IDX_W'(BYTE_BITS)) begin
								rx_n = shift_q;
								enter_ph = PH_AK_PRE;
							end else begin
								enter_ph = PH_RD_HIGH;
							end
						end
						PH_AK_PRE: enter_ph = PH_AK_SET;
						PH_AK_SET: enter_ph = PH_AK_HIGH;
						PH_AK_HIGH: enter_ph = PH_AK_LOW;
						default: begin
							do_enter = 1'b0;
							phase_n = PH_IDLE;
							tick_n = '0;
							done_n = 1'b1;
						end
					endcase
				end
			end
		endcase

		if (do_enter) begin
			phase_n = enter_ph;
			tick_n = '0;
			case (enter_ph)
				PH_ST_A: begin
					scl_n = 1'b1;
					sda_n = 1'b1;
					drv_n = 1'b1;
				end
				PH_ST_B: sda_n = 1'b0;
				PH_ST_C: scl_n = 1'b0;
				PH_SP_A, PH_WR_PRE, PH_AK_PRE: begin
					scl_n = 1'b0;
					sda_n = 1'b0;
					drv_n = 1'b1;
				end
				PH_SP_B: scl_n = 1'b1;
				PH_SP_C: sda_n = 1'b1;
				PH_WR_LOW: begin
					scl_n = 1'b0;
					sda_n = shift_n[BYTE_BITS-1];
					drv_n = 1'b1;
				end
				PH_WR_HIGH, PH_WA_HIGH, PH_RD_HIGH, PH_AK_HIGH: scl_n = 1'b1;
				PH_WA_REL, PH_RD_PRE: begin
					scl_n = 1'b0;
					sda_n = 1'b1;
					drv_n = 1'b0;
				end
				PH_WA_POLL: wait_n = '0;
				PH_WA_END, PH_RD_LOW, PH_AK_LOW: scl_n = 1'b0;
				PH_AK_SET: sda_n = ackb_q;
				default: phase_n = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q <= '0;
			tick_q <= '0;
			wait_q <= '0;
			shift_q <= '0;
			rx_q <= '0;
			ackb_q <= 1'b0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			drv_q <= 1'b1;
			acked_q <= 1'b0;
			to_q <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_n;
			bit_q <= bit_n;
			tick_q <= tick_n;
			wait_q <= wait_n;
			shift_q <= shift_n;
			rx_q <= rx_n;
			ackb_q <= ackb_n;
			scl_q <= scl_n;
			sda_q <= sda_n;
			drv_q <= drv_n;
			acked_q <= acked_n;
			to_q <= to_n;
		end
	end

	assign res.scl_level = scl_n;
	assign res.sda_level = sda_n;
	assign res.sda_drive = drv_n;
	assign res.busy_res = (phase_n != PH_IDLE);
	assign res.done_res = done_n;
	assign res.rx_byte = rx_n;
	assign res.acked = acked_n;
	assign res.timed_out = to_n;

	a_idle_tick_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> tick_q == '0)
		else $error("tick counter not cleared in idle");

	a_poll_released: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WA_POLL |-> !drv_q && scl_q)
		else $error("SDA driven or SCL low during ack poll");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BIT_IDX_W'(BYTE_BITS))
		else $error("bit index past byte length");

	a_ack_seen: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && phase_q == PH_WA_POLL && !item_s1.sda_sample
		|=> acked_q && !to_q && phase_q == PH_WA_END)
		else $error("ack not recorded");

endmodule

### src/i2cmbe_out_stage.sv
module i2cmbe_out_stage
	import i2cmbe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  res_t res,
	output logic step_en,
	output logic out_valid,
	input  logic out_stall,
	output res_t res_s2
);

	logic out_valid_q;

	assign step_en = valid_s1 && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_s2 <= res;
		end
	end

endmodule

### src/i2c_master_bit_engine_top.sv
// Channel | Handshake            | Payload
// input   | in_valid / in_stall   | cmd_valid, kind, tx_byte, ack_to_send, sda_sample
// output  | out_valid / out_stall | scl_level, sda_level, sda_drive, busy_res, done_res,
//         |                       | rx_byte, acked, timed_out
// config  | cfg_we                | cfg_index, cfg_data
//
// One tick is accepted every clock cycle unless the input stalls. The engine works on the
// tick held in the input register, and its result is registered in the output register.
// Reset clears the bus engine to idle with SCL and SDA driven high and loads the
// register defaults (half period 5, ack timeout 250).
// A stalled output holds its result; the input stalls only while a tick waits in the
// input register behind it.
module i2c_master_bit_engine_top
	import i2cmbe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd_valid,
	input  logic [1:0]            kind,
	input  logic [BYTE_BITS-1:0]  tx_byte,
	input  logic                  ack_to_send,
	input  logic                  sda_sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  scl_level,
	output logic                  sda_level,
	output logic                  sda_drive,
	output logic                  busy_res,
	output logic                  done_res,
	output logic [BYTE_BITS-1:0]  rx_byte,
	output logic                  acked,
	output logic                  timed_out
);

	item_t in_item, item_s1;
	res_t res, res_s2;
	logic valid_s1, step_en;

	assign in_item.cmd_valid = cmd_valid;
	assign in_item.kind = kind;
	assign in_item.tx_byte = tx_byte;
	assign in_item.ack_to_send = ack_to_send;
	assign in_item.sda_sample = sda_sample;

	i2cmbe_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.step_en(step_en),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	i2cmbe_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.step_en(step_en),
		.item_s1(item_s1),
		.res(res)
	);

	i2cmbe_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(valid_s1),
		.res(res),
		.step_en(step_en),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res_s2(res_s2)
	);

	assign scl_level = res_s2.scl_level;
	assign sda_level = res_s2.sda_level;
	assign sda_drive = res_s2.sda_drive;
	assign busy_res = res_s2.busy_res;
	assign done_res = res_s2.done_res;
	assign rx_byte = res_s2.rx_byte;
	assign acked = res_s2.acked;
	assign timed_out = res_s2.timed_out;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked tick");

	a_step_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> out_valid)
		else $error("processed tick did not reach the output register");

	a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !step_en)
		else $error("engine advanced while the output was blocked");

endmodule
